// ===== src/ps2_scancode_translator_core_defines.svh =====
// Assertion macros shared by the scancode translator RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef PS2_SCANCODE_TRANSLATOR_CORE_DEFINES_SVH
`define PS2_SCANCODE_TRANSLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// clocked check, masked while reset is held
`define PS2SC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also runs through reset
`define PS2SC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define PS2SC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PS2SC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/ps2sc_pkg.sv =====
// Shared types and constants for the PS/2 set 1 scancode translator.
// No dependencies; used by every RTL file of the block except ps2sc_ram.
package ps2sc_pkg;

  localparam int unsigned LAYOUT_ENTRIES = 128;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KEY_W   = 7;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SCAN    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_LO = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_UP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UP_ARROW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_ARROW = 1'b1;

  localparam logic [BYTE_W-1:0] UP_ARROW_RESET   = 8'h48;
  localparam logic [BYTE_W-1:0] DOWN_ARROW_RESET = 8'h50;

  // scancodes
  localparam logic [BYTE_W-1:0] CODE_PREFIX = 8'hE0;
  localparam logic [BYTE_W-1:0] CODE_UP     = 8'h48;
  localparam logic [BYTE_W-1:0] CODE_DOWN   = 8'h50;
  localparam logic [KEY_W-1:0]  KEY_LSHIFT  = 7'h2A;
  localparam logic [KEY_W-1:0]  KEY_RSHIFT  = 7'h36;
  localparam logic [KEY_W-1:0]  KEY_CAPS    = 7'h3A;

  typedef struct packed {
    logic              caps_on;
    logic              shift_held;
    logic              released;
    logic [BYTE_W-1:0] character;
    logic [BYTE_W-1:0] key_code;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

// ===== src/ps2_scancode_translator_core.sv =====
// Top level of the PS/2 set 1 scancode translator.
// Depends on ps2sc_pkg, ps2sc_front, ps2sc_queue and ps2sc_back.

// Takes one word per clock while in_tready is high: PS/2 set 1 scancode bytes
// and layout table loads. Shift, caps lock and the 0xE0 prefix are tracked here;
// each scancode byte other than a leading 0xE0 yields one result word with the code
// and, for a make code without prefix, the character from the lower or upper layout
// table. Throughput is one word per cycle while in_tready is high, set by the single
// read port of each layout RAM used at accept time; a result passes the RAM read,
// the queue and the output register. Tables must be loaded before they are looked up.
module ps2_scancode_translator_core #(
  parameter int unsigned LAYOUT_ENTRIES = ps2sc_pkg::LAYOUT_ENTRIES,
  parameter int unsigned QUEUE_DEPTH    = ps2sc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action[1:0]
  input  logic [ps2sc_pkg::ACT_W-1:0]       in_tuser,
  // data_byte[7:0], table_index[14:8], table_value[22:15], zero pad
  input  logic [ps2sc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // key_code[7:0], character[15:8], released[16], shift_held[17], caps_on[18], zero pad
  output logic [ps2sc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [ps2sc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2sc_pkg::BYTE_W-1:0]      cfg_wdata
);

  logic            q_ready, q_push, q_valid, q_pop;
  ps2sc_pkg::res_t q_data, q_head;

  ps2sc_front #(
    .LAYOUT_ENTRIES (LAYOUT_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  ps2sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ps2sc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/ps2sc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ps2sc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ps2sc_front.sv =====
// Front end: takes input words, tracks shift/caps/prefix state, owns both layout RAMs.
// Depends on ps2sc_pkg and ps2sc_ram; hands finished records to the queue.
`include "ps2_scancode_translator_core_defines.svh"

module ps2sc_front #(
  parameter int unsigned LAYOUT_ENTRIES = ps2sc_pkg::LAYOUT_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ps2sc_pkg::ACT_W-1:0]         in_tuser,
  input  logic [ps2sc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                cfg_we,
  input  logic [ps2sc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ps2sc_pkg::BYTE_W-1:0]        cfg_wdata,
  input  logic                                q_ready,
  output logic                                q_push,
  output ps2sc_pkg::res_t                     q_data
);

  localparam int unsigned AW = $clog2(LAYOUT_ENTRIES);

  logic [ps2sc_pkg::BYTE_W-1:0] up_code_r, down_code_r;
  logic prefix_r, prefix_nxt;
  logic lshift_r, lshift_nxt;
  logic rshift_r, rshift_nxt;
  logic caps_r, caps_nxt;

  logic            s1_valid_r, s1_valid_nxt;
  ps2sc_pkg::res_t s1_res_r, s1_res_nxt;
  logic            s1_char_r, s1_char_nxt;
  logic            s1_upper_r, s1_upper_nxt;

  logic                          acc;
  logic [ps2sc_pkg::ACT_W-1:0]   action;
  logic [ps2sc_pkg::BYTE_W-1:0]  data_byte;
  logic [ps2sc_pkg::KEY_W-1:0]   table_index;
  logic [ps2sc_pkg::BYTE_W-1:0]  table_value;
  logic                          rel;
  logic [ps2sc_pkg::KEY_W-1:0]   key;
  logic                          is_scan;
  logic                          gives_result;
  logic [ps2sc_pkg::BYTE_W-1:0]  lo_rdata, up_rdata;

  assign acc         = in_tvalid && in_tready;
  assign action      = in_tuser;
  assign data_byte   = in_tdata[7:0];
  assign table_index = in_tdata[14:8];
  assign table_value = in_tdata[22:15];
  assign rel         = data_byte[7];
  assign key         = data_byte[6:0];
  assign is_scan     = (action == ps2sc_pkg::ACT_SCAN);

  assign in_tready = !s1_valid_r || q_ready;

  always_comb begin
    prefix_nxt   = prefix_r;
    lshift_nxt   = lshift_r;
    rshift_nxt   = rshift_r;
    caps_nxt     = caps_r;
    gives_result = 1'b0;
    s1_res_nxt   = s1_res_r;
    s1_char_nxt  = s1_char_r;
    s1_upper_nxt = s1_upper_r;
    if (acc && is_scan) begin
      if (prefix_r) begin
        // extended byte: arrows only, modifiers untouched
        prefix_nxt   = 1'b0;
        gives_result = 1'b1;
        s1_char_nxt  = 1'b0;
        s1_res_nxt.key_code = '0;
        if (data_byte == ps2sc_pkg::CODE_UP) begin
          s1_res_nxt.key_code = up_code_r;
        end else if (data_byte == ps2sc_pkg::CODE_DOWN) begin
          s1_res_nxt.key_code = down_code_r;
        end
      end else if (data_byte == ps2sc_pkg::CODE_PREFIX) begin
        prefix_nxt = 1'b1;
      end else begin
        gives_result = 1'b1;
        if (key == ps2sc_pkg::KEY_LSHIFT) begin
          lshift_nxt = !rel;
        end else if (key == ps2sc_pkg::KEY_RSHIFT) begin
          rshift_nxt = !rel;
        end else if (key == ps2sc_pkg::KEY_CAPS && !rel) begin
          caps_nxt = !caps_r;
        end
        s1_res_nxt.key_code = data_byte;
        s1_char_nxt         = !rel;
      end
      s1_res_nxt.character  = '0;
      s1_res_nxt.released   = rel;
      s1_res_nxt.shift_held = lshift_nxt || rshift_nxt;
      s1_res_nxt.caps_on    = caps_nxt;
      s1_upper_nxt          = caps_nxt ^ (lshift_nxt || rshift_nxt);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = gives_result;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_code_r   <= ps2sc_pkg::UP_ARROW_RESET;
      down_code_r <= ps2sc_pkg::DOWN_ARROW_RESET;
      prefix_r    <= 1'b0;
      lshift_r    <= 1'b0;
      rshift_r    <= 1'b0;
      caps_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ps2sc_pkg::CFG_UP_ARROW:   up_code_r   <= cfg_wdata;
          ps2sc_pkg::CFG_DOWN_ARROW: down_code_r <= cfg_wdata;
          default: ;
        endcase
      end
      prefix_r   <= prefix_nxt;
      lshift_r   <= lshift_nxt;
      rshift_r   <= rshift_nxt;
      caps_r     <= caps_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r   <= s1_res_nxt;
    s1_char_r  <= s1_char_nxt;
    s1_upper_r <= s1_upper_nxt;
  end

  // both tables read at the key on every scan word; data lands with stage 1
  ps2sc_ram #(
    .WIDTH (ps2sc_pkg::BYTE_W),
    .DEPTH (LAYOUT_ENTRIES)
  ) u_lower_ram (
    .clk   (clk),
    .we    (acc && action == ps2sc_pkg::ACT_LOAD_LO),
    .waddr (table_index[AW-1:0]),
    .wdata (table_value),
    .re    (acc && is_scan),
    .raddr (key[AW-1:0]),
    .rdata (lo_rdata)
  );

  ps2sc_ram #(
    .WIDTH (ps2sc_pkg::BYTE_W),
    .DEPTH (LAYOUT_ENTRIES)
  ) u_upper_ram (
    .clk   (clk),
    .we    (acc && action == ps2sc_pkg::ACT_LOAD_UP),
    .waddr (table_index[AW-1:0]),
    .wdata (table_value),
    .re    (acc && is_scan),
    .raddr (key[AW-1:0]),
    .rdata (up_rdata)
  );

  assign q_push = s1_valid_r && q_ready;

  always_comb begin
    q_data = s1_res_r;
    if (s1_char_r) begin
      q_data.character = s1_upper_r ? up_rdata : lo_rdata;
    end
  end

  `PS2SC_ASSERT(a_prefix_arms, clk, rst_n,
    (acc && is_scan && !prefix_r && data_byte == ps2sc_pkg::CODE_PREFIX) |=> prefix_r,
    "0xE0 accepted without prefix did not arm it")
  `PS2SC_ASSERT(a_release_no_char, clk, rst_n,
    (s1_valid_r && s1_res_r.released) |-> !s1_char_r,
    "release record marked for a table lookup")

endmodule

// ===== src/ps2sc_queue.sv =====
// Short FIFO of result records between front end and output stage.
// Depends on ps2sc_pkg.
`include "ps2_scancode_translator_core_defines.svh"

module ps2sc_queue #(
  parameter int unsigned DEPTH = ps2sc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ps2sc_pkg::res_t push_data,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output ps2sc_pkg::res_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ps2sc_pkg::res_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign ready = (count_r < CW'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  `PS2SC_ASSERT(a_count_bound, clk, rst_n,
    count_r <= CW'(DEPTH),
    "queue fill count above depth")

endmodule

// ===== src/ps2sc_back.sv =====
// Output stage: pops result records into the registered result port.
// Depends on ps2sc_pkg; fed by ps2sc_queue.
`include "ps2_scancode_translator_core_defines.svh"

module ps2sc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  ps2sc_pkg::res_t                   q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ps2sc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic            out_valid_r, out_valid_nxt;
  ps2sc_pkg::res_t out_res_r;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= q_head;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ps2sc_pkg::OUT_TDATA_W - ps2sc_pkg::RES_W)'(0), out_res_r};

  `PS2SC_ASSERT_ALWAYS(a_reset_empty, clk,
    !rst_n |=> !out_tvalid,
    "result port valid right after reset")

endmodule
